// File: rtl/brff_pkg.sv
// ----------------------------------------------------------------------------
// brff_pkg
// Types, constants and handshake structs shared by the bitmap range
// update / find-first block.
// ----------------------------------------------------------------------------
package brff_pkg;

  // Word geometry of the bitmap storage
  localparam int WORD_BITS    = 64;
  localparam int OFF_W        = 6;
  localparam int MAP_BITS_DEF = 4096;

  // Field widths of the item payloads
  localparam int START_W = 12;
  localparam int CNT_W   = 13;
  localparam int END_W   = 13;
  localparam int IDX_W   = 12;

  // Item kinds
  localparam logic KIND_CHANGE = 1'b0;
  localparam logic KIND_FIND   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [START_W-1:0] start_bit;
    logic [CNT_W-1:0]   bit_count;
    logic [END_W-1:0]   search_end;
    logic               bit_value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] found_index;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_DRAIN,
    ST_RESULT
  } brff_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;    // write zero to the clear-pass word
    logic load;      // capture a new item
    logic rd;        // read the current word, advance the word counter
    logic proc;      // read data is valid: modify or search it
    logic out_load;  // move the search result into the output register
  } brff_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;  // clear pass is on the last word
    logic empty;     // item covers no bit
    logic is_find;   // item is a find
    logic rd_last;   // word counter sits on the last word of the range
    logic hit;       // searched word holds a matching bit
    logic out_free;  // output register can take a result this cycle
  } brff_sts_t;

endpackage

// File: rtl/brff_ctrl.sv
// ----------------------------------------------------------------------------
// brff_ctrl
// Sequencer for the bitmap block: runs the clear pass after reset, then
// walks each item's words through the datapath and hands off results.
// ----------------------------------------------------------------------------
module brff_ctrl
  import brff_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  brff_sts_t sts,
  output brff_cmd_t cmd
);

  brff_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_START;
      end
      ST_START: begin
        if (sts.empty) begin
          state_nxt = sts.is_find ? ST_RESULT : ST_IDLE;
        end else begin
          state_nxt = sts.rd_last ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.is_find && sts.hit) begin
          state_nxt = ST_RESULT;
        end else if (sts.rd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = sts.is_find ? ST_RESULT : ST_IDLE;
      end
      ST_RESULT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_START: begin
        cmd.rd = !sts.empty;
      end
      ST_RUN: begin
        cmd.proc = 1'b1;
        cmd.rd   = !(sts.is_find && sts.hit);
      end
      ST_DRAIN: begin
        cmd.proc = 1'b1;
      end
      ST_RESULT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Checks
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while output register busy");

  a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_en |-> in_stall)
    else $error("item accepted during clear pass");

  a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && sts.is_find && sts.hit) |=> state_r == ST_RESULT)
    else $error("find hit did not end the walk");

endmodule

// File: rtl/brff_dp.sv
// ----------------------------------------------------------------------------
// brff_dp
// Datapath for the bitmap block: word memory, item setup, word counter,
// read-modify-write of change runs, match search and output register.
// ----------------------------------------------------------------------------
module brff_dp
  import brff_pkg::*;
#(
  parameter int MAP_BITS = MAP_BITS_DEF
)(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  brff_cmd_t cmd,
  output brff_sts_t sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int PW_MAP     = $clog2(MAP_BITS + 1);
  localparam int PW         = (PW_MAP > 14) ? PW_MAP : 14;
  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

  // Lowest set bit of a word
  function automatic logic [OFF_W-1:0] low_one(input logic [WORD_BITS-1:0] v);
    logic [OFF_W-1:0] r;
    r = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (v[k]) r = OFF_W'(k);
    end
    return r;
  endfunction

  // Item setup: clip the range and split it into words
  logic [PW-1:0] start_ext, stop_sum, map_lim, chg_end, fnd_end, end_sel, last_pos;
  logic          empty_nxt;

  always_comb begin
    map_lim   = PW'(MAP_BITS);
    start_ext = PW'(in_data.start_bit);
    stop_sum  = start_ext + PW'(in_data.bit_count);
    chg_end   = (stop_sum > map_lim) ? map_lim : stop_sum;
    fnd_end   = (PW'(in_data.search_end) > map_lim) ? map_lim : PW'(in_data.search_end);
    end_sel   = (in_data.kind == KIND_FIND) ? fnd_end : chg_end;
    empty_nxt = (start_ext >= end_sel);
    last_pos  = end_sel - PW'(1);
  end

  logic             kind_r, val_r, empty_r;
  logic [WAW-1:0]   fw_r, lw_r, wc_r, dw_r, clr_r;
  logic [OFF_W-1:0] lo_r, hi_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_data.kind;
      val_r   <= in_data.bit_value;
      empty_r <= empty_nxt;
      fw_r    <= start_ext[OFF_W +: WAW];
      lw_r    <= last_pos[OFF_W +: WAW];
      lo_r    <= start_ext[OFF_W-1:0];
      hi_r    <= last_pos[OFF_W-1:0];
    end
  end

  // Word counter and the word index of the data in flight
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wc_r <= start_ext[OFF_W +: WAW];
    end else if (cmd.rd) begin
      wc_r <= wc_r + WAW'(1);
    end
    if (cmd.rd) dw_r <= wc_r;
  end

  // Clear pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_r <= clr_r + WAW'(1);
    end
  end

  // Word memory, one write and one read port, registered read data
  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rdata_r, new_word, wdata;
  logic [WAW-1:0]       waddr;
  logic                 we;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) rdata_r <= mem[wc_r];
  end

  // Range mask of the word in flight, change and search logic
  logic [WORD_BITS-1:0] lo_mask, hi_mask, mask, match;
  logic                 hit;

  always_comb begin
    lo_mask  = (dw_r == fw_r) ? (ONES << lo_r) : ONES;
    hi_mask  = (dw_r == lw_r) ? (ONES >> (OFF_W'(WORD_BITS - 1) - hi_r)) : ONES;
    mask     = lo_mask & hi_mask;
    new_word = val_r ? (rdata_r | mask) : (rdata_r & ~mask);
    match    = (val_r ? rdata_r : ~rdata_r) & mask;
    hit      = (|match) && (kind_r == KIND_FIND);
    we       = cmd.clr_en || (cmd.proc && kind_r == KIND_CHANGE);
    waddr    = cmd.clr_en ? clr_r : dw_r;
    wdata    = cmd.clr_en ? '0 : new_word;
  end

  // Search result
  logic             res_found_r;
  logic [IDX_W-1:0] res_idx_r;
  logic [PW-1:0]    hit_pos;

  assign hit_pos = PW'({dw_r, low_one(match)});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_found_r <= 1'b0;
      res_idx_r   <= '0;
    end else if (cmd.proc && hit) begin
      res_found_r <= 1'b1;
      res_idx_r   <= hit_pos[IDX_W-1:0];
    end
  end

  // Output register
  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.found       <= res_found_r;
      out_data_r.found_index <= res_idx_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status to the controller
  always_comb begin
    sts.clr_last = (clr_r == WAW'(WORD_COUNT - 1));
    sts.empty    = empty_r;
    sts.is_find  = (kind_r == KIND_FIND);
    sts.rd_last  = (wc_r == lw_r);
    sts.hit      = hit;
    sts.out_free = !out_valid_r || !out_stall;
  end

  // Checks
  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (we && cmd.rd) |-> (waddr != wc_r))
    else $error("read and write of the same word in one cycle");

endmodule

// File: rtl/bitmap_range_update_find_first_top.sv
// ----------------------------------------------------------------------------
// bitmap_range_update_find_first_top
// Bitmap of MAP_BITS bits with range set/clear and find-first-match.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one item at a time.
//   A change item sets or clears a run of bits and gives no result; a find
//   item gives one result on the output channel (out_valid / out_stall /
//   out_data) with found and the index of the first matching bit.
//   The map lives in a 64-bit word memory, one word read per cycle with a
//   registered read; a change writes each word back in the cycle after its
//   read. An item walks the words of its range in order, at most
//   ceil(MAP_BITS / 64) words; a find ends early at the first word that
//   holds a match, and its result goes to the output register before the
//   next item is accepted. An item that covers no bit reads no word; a
//   find of that kind still gives a result.
//   After reset the block zeroes the map, one word per cycle, all
//   ceil(MAP_BITS / 64) words with in_stall high, then accepts items.
//   A finished result waits in the output register while out_stall is high;
//   the next item is still accepted, and only a second result waits for it.
// ----------------------------------------------------------------------------
module bitmap_range_update_find_first_top
  import brff_pkg::*;
#(
  parameter int MAP_BITS = MAP_BITS_DEF
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  brff_cmd_t cmd;
  brff_sts_t sts;

  brff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  brff_dp #(
    .MAP_BITS (MAP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/sv/bitmap_range_update_find_first_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_range_update_find_first_top_tb
// Self-checking bench for the bitmap range set/clear and find-first block.
// A mirror of the bitmap is kept in the bench and updated on every accepted
// change item. Every accepted find item is searched in the mirror, and the
// predicted result is queued. Results from the block are checked in order
// against that queue. Directed corner cases come first, then sparse-map
// searches and random traffic with random idle bursts on both sides, output
// back-pressure, a drain pause, and a final stretch at full rate.
// ----------------------------------------------------------------------------
module bitmap_range_update_find_first_top_tb;
  import brff_pkg::*;

  localparam int MAP_SIZE   = MAP_BITS_DEF;
  localparam int WORD_COUNT = MAP_SIZE / WORD_BITS;
  localparam int FIELD_MAX  = 8191;  // largest 13-bit count / end value

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // Bench copy of the bitmap and the results still owed by the block
  logic [WORD_BITS-1:0] bitmap_mirror [WORD_COUNT];
  out_item_t            pending_finds [$];

  int  mismatch_count  = 0;
  int  results_checked = 0;
  int  items_sent      = 0;
  int  finds_sent      = 0;
  bit  idle_on         = 1'b1;
  int  hold_cycles     = 0;
  int  stall_left      = 0;

  bitmap_range_update_find_first_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the bitmap
  // ---------------------------------------------------------------------------

  // Set or clear a run, clipped at the end of the map
  function automatic void mirror_change(in_item_t it);
    int unsigned stop;
    stop = int'(it.start_bit) + int'(it.bit_count);
    if (stop > MAP_SIZE) stop = MAP_SIZE;
    for (int unsigned i = it.start_bit; i < stop; i++)
      bitmap_mirror[i / WORD_BITS][i % WORD_BITS] = it.bit_value;
  endfunction

  // First bit equal to bit_value in [start_bit, min(search_end, MAP_SIZE))
  function automatic out_item_t mirror_find(in_item_t it);
    out_item_t   res;
    int unsigned stop;
    res  = '0;
    stop = it.search_end;
    if (stop > MAP_SIZE) stop = MAP_SIZE;
    for (int unsigned i = it.start_bit; i < stop && !res.found; i++) begin
      if (bitmap_mirror[i / WORD_BITS][i % WORD_BITS] == it.bit_value) begin
        res.found       = 1'b1;
        res.found_index = i[IDX_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic in_item_t make_item(logic kind, int unsigned start,
                                         int unsigned count, int unsigned stop_at,
                                         logic val);
    in_item_t it;
    it.kind       = kind;
    it.start_bit  = start[START_W-1:0];
    it.bit_count  = count[CNT_W-1:0];
    it.search_end = stop_at[END_W-1:0];
    it.bit_value  = val;
    return it;
  endfunction

  // Random item: mostly short runs and short searches, a few map-wide ones
  function automatic in_item_t rand_item();
    int unsigned start, count, stop_at, sel;
    logic        kind;
    kind = logic'($urandom_range(0, 1));
    sel  = $urandom_range(0, 99);
    if (sel < 10) start = MAP_SIZE - $urandom_range(1, 70);
    else          start = $urandom_range(0, MAP_SIZE - 1);
    sel = $urandom_range(0, 99);
    if (sel < 75)      count = $urandom_range(0, 130);
    else if (sel < 92) count = $urandom_range(0, 1024);
    else if (sel < 98) count = $urandom_range(0, MAP_SIZE);
    else               count = $urandom_range(MAP_SIZE + 1, FIELD_MAX);
    sel = $urandom_range(0, 99);
    if (sel < 65)      stop_at = start + $urandom_range(0, 200);
    else if (sel < 80) stop_at = MAP_SIZE;
    else if (sel < 95) stop_at = $urandom_range(0, MAP_SIZE);
    else               stop_at = $urandom_range(MAP_SIZE + 1, FIELD_MAX);
    return make_item(kind, start, count, stop_at, logic'($urandom_range(0, 1)));
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Present one item from a falling edge; returns at the accepting rising edge
  // with valid still high, so back-to-back items keep valid up.
  task automatic send_item(in_item_t it);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (it.kind == KIND_FIND) begin
      finds_sent++;
      pending_finds.push_back(mirror_find(it));
    end else begin
      mirror_change(it);
    end
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_input();
    while (pending_finds.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall bursts, long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_finds.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual found=%0b index=%0d",
                 $time, out_data.found, out_data.found_index);
      end else begin
        want = pending_finds.pop_front();
        results_checked++;
        if (out_data.found !== want.found) begin
          mismatch_count++;
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $time, want.found, out_data.found);
        end
        if (out_data.found_index !== want.found_index) begin
          mismatch_count++;
          $display("%0t: found_index mismatch, expected %0d, actual %0d",
                   $time, want.found_index, out_data.found_index);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner cases on a known map
  task automatic test_directed();
    send_item(make_item(KIND_FIND,   0,    0,         MAP_SIZE,  1'b1)); // empty map
    send_item(make_item(KIND_FIND,   0,    0,         MAP_SIZE,  1'b0));
    send_item(make_item(KIND_CHANGE, 100,  0,         0,         1'b1)); // zero count
    send_item(make_item(KIND_FIND,   0,    0,         MAP_SIZE,  1'b1));
    send_item(make_item(KIND_CHANGE, 4095, MAP_SIZE,  0,         1'b1)); // clipped run
    send_item(make_item(KIND_FIND,   4000, 0,         MAP_SIZE,  1'b1));
    send_item(make_item(KIND_CHANGE, 0,    1,         0,         1'b1));
    send_item(make_item(KIND_FIND,   0,    0,         FIELD_MAX, 1'b1)); // end past map
    send_item(make_item(KIND_FIND,   4095, 0,         4095,      1'b1)); // empty search
    send_item(make_item(KIND_FIND,   10,   0,         5,         1'b0)); // end below start
    send_item(make_item(KIND_CHANGE, 60,   10,        0,         1'b1)); // word boundary
    send_item(make_item(KIND_FIND,   2,    0,         MAP_SIZE,  1'b1));
    send_item(make_item(KIND_FIND,   60,   0,         MAP_SIZE,  1'b0));
    send_item(make_item(KIND_FIND,   61,   0,         65,        1'b0)); // not found
    send_item(make_item(KIND_CHANGE, 0,    FIELD_MAX, 0,         1'b1)); // fill all
    send_item(make_item(KIND_FIND,   0,    0,         MAP_SIZE,  1'b0));
    send_item(make_item(KIND_FIND,   4095, 0,         MAP_SIZE,  1'b1));
    send_item(make_item(KIND_CHANGE, 2048, 1,         0,         1'b0));
    send_item(make_item(KIND_FIND,   0,    0,         FIELD_MAX, 1'b0));
    send_item(make_item(KIND_CHANGE, 127,  130,       0,         1'b0)); // multi-word
    send_item(make_item(KIND_FIND,   1,    0,         MAP_SIZE,  1'b0));
    send_item(make_item(KIND_FIND,   200,  0,         MAP_SIZE,  1'b1));
    send_item(make_item(KIND_CHANGE, 0,    4095,      0,         1'b0));
    send_item(make_item(KIND_FIND,   0,    0,         MAP_SIZE,  1'b1)); // only last bit
    send_item(make_item(KIND_CHANGE, 0,    MAP_SIZE,  0,         1'b0)); // clear all
  endtask

  // Few marked bits in a uniform map: long searches across many words
  task automatic test_sparse_search();
    for (int round = 0; round < 4; round++) begin
      logic fill;
      fill = round[0];
      send_item(make_item(KIND_CHANGE, 0, MAP_SIZE, 0, fill));
      repeat (4)
        send_item(make_item(KIND_CHANGE, $urandom_range(0, MAP_SIZE - 1),
                            $urandom_range(1, 3), 0, ~fill));
      repeat (18)
        send_item(make_item(KIND_FIND,
                            ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAP_SIZE - 1),
                            $urandom_range(0, FIELD_MAX),
                            ($urandom_range(0, 1) == 0) ? MAP_SIZE
                                                        : $urandom_range(0, FIELD_MAX),
                            ~fill));
    end
  endtask

  task automatic test_random_mix(int n);
    repeat (n) send_item(rand_item());
  endtask

  // Receiver holds off while the sender keeps offering finds
  task automatic test_result_backpressure();
    bit saved;
    saved       = idle_on;
    idle_on     = 1'b0;
    hold_cycles = 400;
    repeat (30)
      send_item(make_item(KIND_FIND, $urandom_range(0, MAP_SIZE - 1), 0, MAP_SIZE,
                          logic'($urandom_range(0, 1))));
    idle_on = saved;
  endtask

  // Sender waits for every owed result before going on
  task automatic test_drain_pause();
    repeat (4) begin
      repeat (10) send_item(rand_item());
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    for (int w = 0; w < WORD_COUNT; w++) bitmap_mirror[w] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_sparse_search();
    test_random_mix(1150);
    test_result_backpressure();
    test_drain_pause();
    idle_on = 1'b0;
    test_random_mix(220);

    // Let the last items finish, then watch for stray results
    wait_drained();
    repeat (100) @(posedge clk);

    $display("Sent %0d items (%0d finds, %0d changes); %0d results checked.",
             items_sent, finds_sent, items_sent - finds_sent, results_checked);
    $display("Covered clipped runs, empty and out-of-map searches, sparse maps, stalls.");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
